[rtl/core/phe_pkg.sv]
// Shared types and constants for the pixel histogram engine.
package phe_pkg;

  localparam logic [1:0] CMD_COUNT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] pixel_or_bin;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic        out_of_range;
    logic [31:0] pixels_seen;
  } out_beat_t;

  // Classified operation handed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic        oor;
    logic [15:0] idx;
  } op_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } back_stat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } back_state_t;

endpackage

[rtl/core/pixel_histogram_engine.sv]
// Top level of the pixel histogram engine.
//
//  channel  | ports                      | beat accepted when
//  ---------+----------------------------+---------------------
//  input    | push, full, in_data        | push && !full
//  result   | empty, pop, out_data       | pop && !empty
//
// In the back end the bin memory is read in the cycle a command is taken, then
// written and the result queued in the next cycle.
// After reset a clearing pass zeroes the bins, with full held high throughout.
// A two-entry command queue and a two-entry result queue let either side stall
// without stopping the other; the back end waits only when the result queue is full.
module pixel_histogram_engine #(
  parameter int unsigned NUM_BINS    = 1024,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  phe_pkg::in_beat_t  in_data,
  output logic               empty,
  input  logic               pop,
  output phe_pkg::out_beat_t out_data
);

  logic                op_valid;
  phe_pkg::op_t        op;
  phe_pkg::back_stat_t stat;
  logic                res_full;
  logic                res_push;
  phe_pkg::out_beat_t  res;

  phe_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op       (op),
    .stat     (stat)
  );

  phe_back #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .stat     (stat),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  phe_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res),
    .empty (empty),
    .pop   (pop),
    .dout  (out_data)
  );

endmodule

[rtl/core/phe_front.sv]
// Front end: accepts input beats, classifies them, and queues them for the back end.
module phe_front #(
  parameter int unsigned NUM_BINS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  phe_pkg::in_beat_t   in_data,
  output logic                op_valid,
  output phe_pkg::op_t        op,
  input  phe_pkg::back_stat_t stat
);

  phe_pkg::op_t q_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         wr, rd;
  logic         known_cmd;
  phe_pkg::op_t new_op;

  assign full     = stat.clearing || (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rd_ptr_r];
  assign wr       = push && !full;
  assign rd       = stat.take;

  // Unused command code flags nothing and touches no state
  assign known_cmd = (in_data.command == phe_pkg::CMD_COUNT) ||
                     (in_data.command == phe_pkg::CMD_READ)  ||
                     (in_data.command == phe_pkg::CMD_CLEAR);

  always_comb begin
    new_op.cmd = in_data.command;
    new_op.idx = in_data.pixel_or_bin;
    new_op.oor = known_cmd && ({1'b0, in_data.pixel_or_bin} >= 17'(NUM_BINS));
  end

  always_comb begin
    wr_ptr_nxt = wr ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, wr} - {1'b0, rd});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_ptr_r] <= new_op;
    end
  end

endmodule

[rtl/core/phe_back.sv]
// Back end: bin memory read-modify-write, pixel total, and reset clearing pass.
module phe_back #(
  parameter int unsigned NUM_BINS    = 1024,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 op_valid,
  input  phe_pkg::op_t         op,
  output phe_pkg::back_stat_t  stat,
  input  logic                 res_full,
  output logic                 res_push,
  output phe_pkg::out_beat_t   res
);

  localparam int unsigned AW = $clog2(NUM_BINS);

  logic [COUNT_WIDTH-1:0] bin_mem_r [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_r;

  phe_pkg::back_state_t   state_r, state_nxt;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic [31:0]            total_r, total_nxt;
  phe_pkg::op_t           cur_r, cur_nxt;

  logic                   take;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd;
  logic [AW-1:0]          rd_addr;
  logic [COUNT_WIDTH-1:0] inc_val;
  logic [COUNT_WIDTH-1:0] value;
  logic [63:0]            value_ext;

  assign take    = (state_r == phe_pkg::ST_IDLE) && op_valid && !res_full;
  assign rd_addr = op.idx[AW-1:0];
  assign inc_val = (&rd_data_r) ? rd_data_r : rd_data_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      phe_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(NUM_BINS - 1)) begin
          state_nxt = phe_pkg::ST_IDLE;
        end
      end
      phe_pkg::ST_IDLE: begin
        if (take) begin
          state_nxt = phe_pkg::ST_UPDATE;
        end
      end
      phe_pkg::ST_UPDATE: state_nxt = phe_pkg::ST_IDLE;
      default:            state_nxt = phe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    stat.take     = take;
    stat.clearing = (state_r == phe_pkg::ST_CLEAR);
    mem_we        = 1'b0;
    mem_wa        = cur_r.idx[AW-1:0];
    mem_wd        = '0;
    clr_addr_nxt  = clr_addr_r;
    cur_nxt       = take ? op : cur_r;
    total_nxt     = total_r;
    value         = '0;
    res_push      = 1'b0;
    unique case (state_r)
      phe_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      phe_pkg::ST_IDLE: begin
      end
      phe_pkg::ST_UPDATE: begin
        res_push = 1'b1;
        if (!cur_r.oor) begin
          unique case (cur_r.cmd)
            phe_pkg::CMD_COUNT: begin
              mem_we    = 1'b1;
              mem_wd    = inc_val;
              value     = inc_val;
              total_nxt = (total_r == phe_pkg::TOTAL_MAX) ? total_r : total_r + 32'd1;
            end
            phe_pkg::CMD_READ: begin
              value = rd_data_r;
            end
            phe_pkg::CMD_CLEAR: begin
              value  = rd_data_r;
              mem_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    value_ext        = 64'(value);
    res.bin_count    = value_ext[31:0];
    res.out_of_range = cur_r.oor;
    res.pixels_seen  = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= phe_pkg::ST_CLEAR;
      clr_addr_r <= '0;
      total_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Single-port style use: read issued at take, write in the following cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem_r[mem_wa] <= mem_wd;
    end
    if (take) begin
      rd_data_r <= bin_mem_r[rd_addr];
    end
  end

endmodule

[rtl/core/phe_outq.sv]
// Two-entry result queue between the back end and the result ports.
module phe_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  phe_pkg::out_beat_t din,
  output logic               empty,
  input  logic               pop,
  output phe_pkg::out_beat_t dout
);

  phe_pkg::out_beat_t q_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               wr, rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = q_r[rd_ptr_r];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, wr} - {1'b0, rd});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/core/phe_checker.sv]
// Port-level checks for the pixel histogram engine, bound to the top level.
module phe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input phe_pkg::out_beat_t out_data
);

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Clearing pass holds off input right after reset
  a_reset_full: assert property (@(posedge clk) !rst_n |=> full)
    else $error("input not held off during clearing pass");

  // Out-of-range results never carry a count
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.out_of_range) |-> (out_data.bin_count == 32'd0))
    else $error("out-of-range result with nonzero count");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("pending result changed before pop");

endmodule

bind pixel_histogram_engine phe_checker u_phe_checker (.*);

[sim/tb_top.sv]
// Self-checking testbench for the pixel histogram engine.
module tb_top;

  localparam int unsigned NUM_BINS    = 1024;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int          RAND_ITEMS  = 650;
  localparam int          HOLD_CYCLES = 100;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] arg;
    bit          known;
    logic [31:0] cnt;
    logic        oor;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  phe_pkg::in_beat_t  in_data;
  logic               empty;
  logic               pop;
  phe_pkg::out_beat_t out_data;

  // shadow histogram
  logic [COUNT_WIDTH-1:0] hist_bins [NUM_BINS];
  logic [31:0]            hist_total;

  phe_pkg::out_beat_t pending_results [$];
  stim_row_t          dir_rows [$];
  phe_pkg::out_beat_t want;
  int                 mismatch_cnt;
  bit                 hold_req;

  pixel_histogram_engine #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Updates the shadow histogram with one command and returns its result beat.
  function automatic phe_pkg::out_beat_t apply_to_histogram(input phe_pkg::in_beat_t beat);
    phe_pkg::out_beat_t res;
    logic               oor;
    int                 idx;
    res = '0;
    idx = beat.pixel_or_bin;
    oor = (idx >= NUM_BINS);
    case (beat.command)
      phe_pkg::CMD_COUNT: begin
        if (oor) begin
          res.out_of_range = 1'b1;
        end else begin
          if (hist_bins[idx] != '1) hist_bins[idx] = hist_bins[idx] + 1'b1;
          res.bin_count = 32'(hist_bins[idx]);
          if (hist_total != phe_pkg::TOTAL_MAX) hist_total = hist_total + 1;
        end
      end
      phe_pkg::CMD_READ, phe_pkg::CMD_CLEAR: begin
        if (oor) begin
          res.out_of_range = 1'b1;
        end else begin
          res.bin_count = 32'(hist_bins[idx]);
          if (beat.command == phe_pkg::CMD_CLEAR) hist_bins[idx] = '0;
        end
      end
      default: ;
    endcase
    res.pixels_seen = hist_total;
    return res;
  endfunction

  function automatic phe_pkg::in_beat_t random_beat();
    phe_pkg::in_beat_t beat;
    int                sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)      beat.command = phe_pkg::CMD_COUNT;
    else if (sel < 80) beat.command = phe_pkg::CMD_READ;
    else               beat.command = phe_pkg::CMD_CLEAR;
    // hot bins keep hitting back-to-back read-modify-writes of the same bin
    sel = $urandom_range(0, 99);
    if (sel < 45)      beat.pixel_or_bin = 16'($urandom_range(0, 7));
    else if (sel < 85) beat.pixel_or_bin = 16'($urandom_range(0, NUM_BINS - 1));
    else if (sel < 95) beat.pixel_or_bin = 16'($urandom_range(NUM_BINS, 65535));
    else               beat.pixel_or_bin = 16'($urandom);
    return beat;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [15:0] arg, input bit known,
                         input logic [31:0] cnt, input logic oor);
    stim_row_t row;
    row.cmd   = cmd;
    row.arg   = arg;
    row.known = known;
    row.cnt   = cnt;
    row.oor   = oor;
    dir_rows.push_back(row);
  endtask

  // Holds one beat on the input until it is taken, then records its result.
  task automatic offer(input phe_pkg::in_beat_t beat, input bit known,
                       input logic [31:0] cnt, input logic oor);
    phe_pkg::out_beat_t res;
    push    <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (full) @(posedge clk);
    res = apply_to_histogram(beat);
    if (known) begin
      res.bin_count    = cnt;
      res.out_of_range = oor;
    end
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: %h", out_data);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.bin_count !== want.bin_count) begin
          $error("bin_count expected %0d actual %0d", want.bin_count, out_data.bin_count);
          mismatch_cnt++;
        end
        if (out_data.out_of_range !== want.out_of_range) begin
          $error("out_of_range expected %0b actual %0b", want.out_of_range,
                 out_data.out_of_range);
          mismatch_cnt++;
        end
        if (out_data.pixels_seen !== want.pixels_seen) begin
          $error("pixels_seen expected %0d actual %0d", want.pixels_seen,
                 out_data.pixels_seen);
          mismatch_cnt++;
        end
      end
    end
  end

  // receiver: segments of steady pop, random pop and short stalls, plus one long hold
  initial begin
    int  seg_len;
    int  style;
    bit  hold_done;
    pop       = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end
      style   = $urandom_range(0, 3);
      seg_len = (style == 2) ? $urandom_range(1, 6) : $urandom_range(1, 30);
      repeat (seg_len) begin
        @(negedge clk);
        case (style)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= 1'b0;
          default: pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    int burst_left;
    rst_n        = 1'b0;
    push         = 1'b0;
    in_data      = '0;
    mismatch_cnt = 0;
    hold_req     = 1'b0;
    burst_left   = 0;
    for (int i = 0; i < NUM_BINS; i++) hist_bins[i] = '0;
    hist_total = '0;

    //       command             arg        known cnt   oor
    add_row(phe_pkg::CMD_READ,  16'd0,     1,    32'd0, 1'b0);
    add_row(phe_pkg::CMD_READ,  16'd1023,  1,    32'd0, 1'b0);
    add_row(phe_pkg::CMD_READ,  16'd1024,  1,    32'd0, 1'b1);
    add_row(phe_pkg::CMD_CLEAR, 16'hFFFF,  1,    32'd0, 1'b1);
    add_row(phe_pkg::CMD_COUNT, 16'd0,     1,    32'd1, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'd0,     1,    32'd2, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'd1023,  1,    32'd1, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'd1024,  1,    32'd0, 1'b1);
    add_row(phe_pkg::CMD_COUNT, 16'hFFFF,  1,    32'd0, 1'b1);
    add_row(phe_pkg::CMD_READ,  16'd0,     1,    32'd2, 1'b0);
    add_row(phe_pkg::CMD_CLEAR, 16'd0,     1,    32'd2, 1'b0);
    add_row(phe_pkg::CMD_READ,  16'd0,     1,    32'd0, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'd0,     1,    32'd1, 1'b0);
    add_row(phe_pkg::CMD_CLEAR, 16'd0,     1,    32'd1, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'd0,     1,    32'd1, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'h0155,  0,    32'd0, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'h02AA,  0,    32'd0, 1'b0);
    add_row(phe_pkg::CMD_CLEAR, 16'd1023,  1,    32'd1, 1'b0);
    add_row(phe_pkg::CMD_READ,  16'd1023,  1,    32'd0, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'd512,   1,    32'd1, 1'b0);
    add_row(phe_pkg::CMD_COUNT, 16'd512,   1,    32'd2, 1'b0);
    add_row(phe_pkg::CMD_READ,  16'd512,   1,    32'd2, 1'b0);
    add_row(phe_pkg::CMD_CLEAR, 16'd512,   1,    32'd2, 1'b0);
    add_row(phe_pkg::CMD_CLEAR, 16'd512,   1,    32'd0, 1'b0);
    add_row(phe_pkg::CMD_READ,  16'hAAAA,  0,    32'd0, 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      offer('{command: dir_rows[i].cmd, pixel_or_bin: dir_rows[i].arg},
            dir_rows[i].known, dir_rows[i].cnt, dir_rows[i].oor);
      if ($urandom_range(0, 1) == 0) idle_gap($urandom_range(1, 3));
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
      if (i == RAND_ITEMS / 3) hold_req = 1'b1;
      offer(random_beat(), 0, '0, 1'b0);
      burst_left--;
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
